### src/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CFG_WIDTH        = 7;

  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = CFG_WIDTH'(3);

  // Broadcast to every cell of the candidate chain.
  typedef struct packed {
    logic commit;  // a sample transaction is taken this cycle
    logic drop;    // the front candidate leaves; every cell takes its upper neighbor
    logic last;    // the sample closes the array; empty the chain
  } swm_ctrl_t;

endpackage

### src/swm_in_if.sv
`timescale 1ns / 1ps

interface swm_in_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

### src/swm_out_if.sv
`timescale 1ns / 1ps

interface swm_out_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic                           last_result;

  modport source (output valid, window_max, last_result, input ready);
  modport sink   (input valid, window_max, last_result, output ready);
endinterface

### src/sliding_window_max_core.sv
`timescale 1ns / 1ps

// Sliding window maximum over a stream of signed samples.
// sample_stream carries one sample per transaction; last_sample closes an
// array, and the window starts empty for the next one. Once window_size
// samples of the current array have arrived, each further sample yields one
// result transaction on result_stream: the maximum of the last window_size
// samples, with last_result copying the sample's last mark. An array shorter
// than the window yields nothing. window_size is written through
// cfg_we/cfg_wdata; the user must write it only while no transaction is in
// flight, and the block does not enforce this. 0 acts as 1 and values above
// MAX_WINDOW act as MAX_WINDOW. Candidates sit in a chain of MAX_WINDOW
// cells, oldest at cell 0. Each result is registered and offered in the cycle
// after its sample is taken. Throughput is one sample per cycle while at most
// one front candidate is stale; after window_size shrinks, stale front
// candidates beyond the first leave one at a time, with sample_stream.ready
// low, by the single-position shift of the cell chain. Reset empties the
// chain, clears the sample count and sets window_size to 3. When result_stream
// stalls with a result held, sample_stream.ready drops until it is taken.
module sliding_window_max_core
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  swm_in_if.sink               sample_stream,
  swm_out_if.source            result_stream
);

  localparam int AGE_WIDTH = $clog2(MAX_WINDOW + 1);

  logic [CFG_WIDTH-1:0] window_size;
  logic [31:0]          window_raw;
  logic [31:0]          window_clip;
  logic [AGE_WIDTH-1:0] window;
  logic [AGE_WIDTH-1:0] fill_count;
  logic [AGE_WIDTH-1:0] fill_next;
  logic                 produce;
  logic                 accept;
  logic                 drain;
  swm_ctrl_t            ctrl;

  logic                           cell_valid [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_WINDOW];
  logic        [AGE_WIDTH-1:0]    cell_age   [MAX_WINDOW];
  logic                           cell_aged  [MAX_WINDOW];
  logic                           cell_keep  [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] cell_view  [MAX_WINDOW];

  logic signed [SAMPLE_WIDTH-1:0] front_value;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_max;
  logic                           out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  assign window_raw  = 32'(window_size);
  assign window_clip = (window_raw == 32'd0) ? 32'd1 :
                       (window_raw > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : window_raw;
  assign window      = window_clip[AGE_WIDTH-1:0];

  // Only one stale candidate can leave in the same cycle as a new sample.
  assign sample_stream.ready = !(cell_aged[0] && cell_aged[1]) &&
                               (!out_valid || result_stream.ready);
  assign accept = sample_stream.valid && sample_stream.ready;
  assign drain  = sample_stream.valid && cell_aged[0] && cell_aged[1];

  assign ctrl.commit = accept;
  assign ctrl.drop   = accept ? cell_aged[0] : drain;
  assign ctrl.last   = sample_stream.last_sample;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                           up_valid;
    logic signed [SAMPLE_WIDTH-1:0] up_value;
    logic        [AGE_WIDTH-1:0]    up_age;
    logic                           prev_keep;

    if (i == MAX_WINDOW - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_value = '0;
      assign up_age   = '0;
    end else begin : g_mid
      assign up_valid = cell_valid[i+1];
      assign up_value = cell_value[i+1];
      assign up_age   = cell_age[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_tail
      assign prev_keep = cell_keep[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .AGE_WIDTH    (AGE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .window     (window),
      .sample     (sample_stream.sample),
      .up_valid   (up_valid),
      .up_value   (up_value),
      .up_age     (up_age),
      .prev_keep  (prev_keep),
      .valid      (cell_valid[i]),
      .value      (cell_value[i]),
      .age        (cell_age[i]),
      .aged       (cell_aged[i]),
      .keep       (cell_keep[i]),
      .view_value (cell_view[i])
    );
  end

  assign front_value = cell_keep[0] ? cell_view[0] : sample_stream.sample;

  assign fill_next = (fill_count == AGE_WIDTH'(MAX_WINDOW)) ? fill_count
                                                            : fill_count + AGE_WIDTH'(1);
  assign produce   = fill_next >= window;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= sample_stream.last_sample ? '0 : fill_next;
    end
  end

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= produce;
    end else if (result_stream.ready) begin
      out_valid <= 1'b0;
    end
    if (accept && produce) begin
      out_max  <= front_value;
      out_last <= sample_stream.last_sample;
    end
  end

  assign result_stream.valid       = out_valid;
  assign result_stream.window_max  = out_max;
  assign result_stream.last_result = out_last;

endmodule

### src/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int AGE_WIDTH    = $clog2(MAX_WINDOW_DEF + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  swm_ctrl_t                      ctrl,
  input  logic        [AGE_WIDTH-1:0]    window,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           up_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] up_value,
  input  logic        [AGE_WIDTH-1:0]    up_age,
  input  logic                           prev_keep,
  output logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic        [AGE_WIDTH-1:0]    age,
  output logic                           aged,
  output logic                           keep,
  output logic signed [SAMPLE_WIDTH-1:0] view_value
);

  logic                           view_valid;
  logic        [AGE_WIDTH-1:0]    view_age;
  logic                           valid_next;
  logic signed [SAMPLE_WIDTH-1:0] value_next;
  logic        [AGE_WIDTH-1:0]    age_next;

  assign aged       = valid && (age >= window);
  assign view_valid = ctrl.drop ? up_valid : valid;
  assign view_value = ctrl.drop ? up_value : value;
  assign view_age   = ctrl.drop ? up_age   : age;
  // Candidates strictly below the new sample leave; equal ones stay.
  assign keep       = view_valid && !(view_value < sample);

  always_comb begin
    valid_next = valid;
    value_next = value;
    age_next   = age;
    if (ctrl.commit) begin
      if (ctrl.last) begin
        valid_next = 1'b0;
      end else if (keep) begin
        valid_next = 1'b1;
        value_next = view_value;
        age_next   = view_age + AGE_WIDTH'(1);
      end else if (prev_keep) begin
        // first free slot behind the kept run takes the new sample
        valid_next = 1'b1;
        value_next = sample;
        age_next   = AGE_WIDTH'(1);
      end else begin
        valid_next = 1'b0;
      end
    end else if (ctrl.drop) begin
      valid_next = up_valid;
      value_next = up_value;
      age_next   = up_age;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
    age   <= age_next;
  end

endmodule

### tb/sv/sliding_window_max_core_test.sv
`timescale 1ns / 1ps

module sliding_window_max_core_test;
  import swm_pkg::*;

  localparam int MAXW         = MAX_WINDOW_DEF;
  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int TAG_SPAN     = 2 * MAXW;
  // stale front candidates may hold off the sender after a shrink
  localparam int SETTLE       = MAXW + 16;
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_CYCLES  = 100;
  localparam int NUM_ROWS     = 26;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    sample_t wmax;
    logic    lr;
  } window_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_WIDTH-1:0] win;
    sample_t              smp;
    logic                 lst;
    logic                 typed;
    logic                 has;
    sample_t              wmax;
    logic                 lr;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_WIDTH-1:0] cfg_wdata;

  swm_in_if  #(.SAMPLE_WIDTH(SW)) sample_if ();
  swm_out_if #(.SAMPLE_WIDTH(SW)) result_if ();

  sliding_window_max_core #(
    .MAX_WINDOW  (MAXW),
    .SAMPLE_WIDTH(SW)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_stream(sample_if),
    .result_stream(result_if)
  );

  // kind, window, sample, last, typed, has result, window_max, last_result
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, 7'd0, 16'sd32767, 1'b0, 1'b1, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, -16'sd32768, 1'b0, 1'b1, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd0, 1'b0, 1'b1, 1'b1, 16'sd32767, 1'b0},
    '{ROW_SAMPLE, 7'd0, -16'sd1, 1'b0, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, -16'sd1, 1'b1, 1'b1, 1'b1, 16'sd0, 1'b1},
    // arrays shorter than the window
    '{ROW_SAMPLE, 7'd0, 16'sd5, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd5, 1'b0, 1'b1, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd7, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0},
    '{ROW_WINDOW, 7'd1, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, -16'sd32768, 1'b0, 1'b1, 1'b1, -16'sd32768, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd32767, 1'b1, 1'b1, 1'b1, 16'sd32767, 1'b1},
    // zero acts as one
    '{ROW_WINDOW, 7'd0, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd123, 1'b0, 1'b1, 1'b1, 16'sd123, 1'b0},
    '{ROW_SAMPLE, 7'd0, -16'sd7, 1'b1, 1'b1, 1'b1, -16'sd7, 1'b1},
    // oversize window clamps to the chain length
    '{ROW_WINDOW, 7'd127, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd1, 1'b1, 1'b1, 1'b0, 16'sd0, 1'b0},
    // equal values, then grow and shrink the window inside one array
    '{ROW_WINDOW, 7'd2, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd4, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd4, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd4, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd3, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WINDOW, 7'd4, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd9, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd1, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_WINDOW, 7'd2, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 7'd0, 16'sd2, 1'b1, 1'b0, 1'b0, 16'sd0, 1'b0}
  };

  // predictor state
  sample_t              cand_val [$];
  int                   cand_tag [$];
  int                   next_tag;
  int                   fill_cnt;
  logic [CFG_WIDTH-1:0] window_reg;

  window_result_t max_due [$];
  int             fault_count   = 0;
  int             results_taken = 0;
  int             hold_at       = -1;
  bit             send_calm     = 1'b0;
  bit             recv_calm     = 1'b0;

  function automatic int live_window();
    if (window_reg == '0) return 1;
    if (window_reg > MAXW) return MAXW;
    return int'(window_reg);
  endfunction

  function automatic void clear_window();
    cand_val.delete();
    cand_tag.delete();
    next_tag = 0;
    fill_cnt = 0;
  endfunction

  function automatic bit advance_window(input sample_t s, input logic lst,
                                        output sample_t wmax);
    int k;
    bit has;
    k    = live_window();
    has  = 1'b0;
    wmax = '0;
    // drop candidates that aged out, then strictly smaller ones at the back
    while (cand_val.size() > 0 && (next_tag + TAG_SPAN - cand_tag[0]) % TAG_SPAN >= k) begin
      cand_val.delete(0);
      cand_tag.delete(0);
    end
    while (cand_val.size() > 0 && cand_val[$] < s) begin
      cand_val.delete(cand_val.size() - 1);
      cand_tag.delete(cand_tag.size() - 1);
    end
    if (cand_val.size() < MAXW) begin
      cand_val = {cand_val, s};
      cand_tag = {cand_tag, next_tag};
    end
    next_tag = (next_tag + 1) % TAG_SPAN;
    if (fill_cnt < MAXW) fill_cnt++;
    if (fill_cnt >= k) begin
      has  = 1'b1;
      wmax = cand_val[0];
    end
    if (lst) clear_window();
    return has;
  endfunction

  function automatic sample_t pick_sample(input int mode);
    case (mode)
      0: return sample_t'(int'($urandom_range(0, 6)) - 3);
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input sample_t s, input logic lst, input bit typed,
                           input bit t_has, input window_result_t t_res);
    int             gap;
    bit             has;
    sample_t        wmax;
    window_result_t due;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid       <= 1'b1;
    sample_if.sample      <= s;
    sample_if.last_sample <= lst;
    do @(posedge clk); while (!sample_if.ready);
    has = advance_window(s, lst, wmax);
    due.wmax = wmax;
    due.lr   = lst;
    if (typed) begin
      has = t_has;
      due = t_res;
    end
    if (has) max_due = {max_due, due};
  endtask

  task automatic go_quiet();
    sample_if.valid <= 1'b0;
    while (max_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_WIDTH-1:0] v);
    go_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int stall;
    int taken;
    taken = 0;
    result_if.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (taken == hold_at) stall = HOLD_CYCLES;
      else stall = recv_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    window_result_t due;
    if (!rst && result_if.valid && result_if.ready) begin
      results_taken++;
      if (max_due.size() == 0) begin
        $error("unexpected result transaction: window_max %0d, last_result %0b",
               result_if.window_max, result_if.last_result);
        fault_count++;
      end else begin
        due = max_due[0];
        max_due.delete(0);
        if (result_if.window_max !== due.wmax) begin
          $error("window_max: expected %0d, actual %0d", due.wmax, result_if.window_max);
          fault_count++;
        end
        if (result_if.last_result !== due.lr) begin
          $error("last_result: expected %0b, actual %0b", due.lr, result_if.last_result);
          fault_count++;
        end
      end
    end
  end

  initial begin
    int sent;
    int left_in_array;
    int mode;
    int k;
    int phase_len;
    bit first;
    logic [CFG_WIDTH-1:0] v;

    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    sample_if.valid       = 1'b0;
    sample_if.sample      = '0;
    sample_if.last_sample = 1'b0;
    window_reg            = WINDOW_SIZE_RESET;
    clear_window();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WINDOW) begin
        write_window(dir_rows[i].win);
      end else begin
        send_item(dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].typed, dir_rows[i].has,
                  '{dir_rows[i].wmax, dir_rows[i].lr});
      end
    end

    sent          = 0;
    left_in_array = 0;
    mode          = 2;
    first         = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: v = 7'd64;
        1: v = 7'd1;
        2: v = 7'd0;
        3: v = 7'd127;
        4: v = CFG_WIDTH'($urandom_range(9, 63));
        default: v = CFG_WIDTH'($urandom_range(1, 8));
      endcase
      // first phase: small window, steady sender, receiver stalls long
      if (first) v = 7'd2;
      write_window(v);
      k = live_window();
      send_calm = first || ($urandom_range(0, 4) == 0);
      recv_calm = !first && ($urandom_range(0, 4) == 0);
      if (first) hold_at = results_taken + 3;
      phase_len = (k > 8) ? k + $urandom_range(10, 40) : $urandom_range(20, 50);
      repeat (phase_len) begin
        if (left_in_array == 0) begin
          if ($urandom_range(0, 7) == 0) left_in_array = $urandom_range(1, k);
          else left_in_array = $urandom_range(k, 2 * k + 10);
          mode = $urandom_range(0, 3);
        end
        left_in_array--;
        send_item(pick_sample(mode), left_in_array == 0, 1'b0, 1'b0, '0);
        sent++;
      end
      first = 1'b0;
    end

    go_quiet();
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
src/swm_pkg.sv
src/swm_in_if.sv
src/swm_out_if.sv
src/swm_cell.sv
src/sliding_window_max_core.sv
tb/sv/sliding_window_max_core_test.sv
